// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the tokenizer top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/mtt_pkg.sv =====
// Types, codes and character-class helpers of the markup tag tokenizer.
`default_nettype none

package mtt_pkg;

  // Lexer modes
  typedef enum logic [2:0] {
    MODE_TEXT     = 3'd0,
    MODE_TAGSTART = 3'd1,
    MODE_TAGNAME  = 3'd2,
    MODE_ATTRGAP  = 3'd3,
    MODE_ATTRNAME = 3'd4,
    MODE_EQUALS   = 3'd5,
    MODE_VALSTART = 3'd6,
    MODE_VALUE    = 3'd7
  } mode_e;

  // Event codes on the result port
  typedef enum logic [3:0] {
    EV_TEXT_CHAR  = 4'd0,
    EV_TEXT_END   = 4'd1,
    EV_NAME_CHAR  = 4'd2,
    EV_NAME_END   = 4'd3,
    EV_ATTR_CHAR  = 4'd4,
    EV_ATTR_END   = 4'd5,
    EV_VALUE_CHAR = 4'd6,
    EV_VALUE_END  = 4'd7,
    EV_TAG_END    = 4'd8,
    EV_ERROR      = 4'd9
  } ev_e;

  // Characters of the grammar
  localparam logic [7:0] ChLt    = 8'd60;
  localparam logic [7:0] ChGt    = 8'd62;
  localparam logic [7:0] ChSlash = 8'd47;
  localparam logic [7:0] ChEq    = 8'd61;
  localparam logic [7:0] ChQuote = 8'd34;
  localparam logic [7:0] ChSpace = 8'd32;

  // Output queue depth: one word in flight plus the two words one byte can give
  localparam int unsigned QDepth = 3;
  localparam int unsigned QIdxW  = $clog2(QDepth + 1);

  // One result word
  typedef struct packed {
    ev_e        ev;
    logic [7:0] data;
    logic       end_tag;
    logic       last;
  } result_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == ChSpace) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return (c >= 8'd48 && c <= 8'd57) || (c >= 8'd65 && c <= 8'd90) ||
           (c >= 8'd97 && c <= 8'd122);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/markup_tag_tokenizer_unit.sv =====
// Top level of the markup tag tokenizer: lexer state machine and result queue.
`default_nettype none

// Streaming tokenizer for a simplified HTML tag grammar. Each accepted byte is
// decided in the cycle it arrives and gives zero, one or two result words,
// which enter a three-word output queue; the words are registered in the
// queue before they reach the output. As long as the output drains, bytes that
// give at most one word are taken at one byte per cycle. A byte
// that ends a tag name and also gives an attribute char, a tag end or an
// error, or that ends an attribute name with a grammar error, gives two words,
// and the single output port then gives them one after the other.
// in_stall_o rises while two or more words wait in the queue. Pending text is
// closed only by a later '<'; there is no end-of-stream flush.
module markup_tag_tokenizer_unit
  import mtt_pkg::*;
(
  input  var logic       clk_i,
  input  var logic       rst_ni,
  // input byte channel
  input  var logic       in_valid_i,
  output logic           in_stall_o,
  input  var logic [7:0] byte_in_i,
  // result channel
  output logic           out_valid_o,
  input  var logic       out_stall_i,
  output logic [3:0]     event_res_o,
  output logic [7:0]     data_byte_o,
  output logic           is_end_tag_o,
  output logic           last_o
);

  // lexer state
  mode_e mode_q, mode_d;
  logic  pend_q, pend_d;
  logic  etag_q, etag_d;

  // queue
  result_t            slot_q [QDepth];
  result_t            slot_d [QDepth];
  logic [QIdxW-1:0]   cnt_q, cnt_d;

  logic               accept, pop;
  result_t            res_a, res_b;
  logic [1:0]         res_n;

  // attribute-gap and equals handling, shared by two modes each
  result_t gap_res, eq_res;
  logic    gap_has, gap_err, eq_err;
  mode_e   gap_mode, eq_mode;

  assign pop        = (cnt_q != '0) && !out_stall_i;
  assign in_stall_o = (cnt_q > QIdxW'(1));
  assign accept     = in_valid_i && !in_stall_o;

  // attribute gap decision
  always_comb begin
    gap_res  = '{ev: EV_ERROR, data: 8'd0, end_tag: etag_q, last: 1'b0};
    gap_has  = 1'b0;
    gap_err  = 1'b0;
    gap_mode = MODE_ATTRGAP;
    if (is_space(byte_in_i)) begin
      gap_mode = MODE_ATTRGAP;
    end else if (is_alnum(byte_in_i)) begin
      gap_res.ev   = EV_ATTR_CHAR;
      gap_res.data = byte_in_i;
      gap_has      = 1'b1;
      gap_mode     = MODE_ATTRNAME;
    end else if (byte_in_i == ChGt) begin
      gap_res.ev = EV_TAG_END;
      gap_has    = 1'b1;
      gap_mode   = MODE_TEXT;
    end else begin
      gap_has  = 1'b1;
      gap_err  = 1'b1;
      gap_mode = MODE_TEXT;
    end
  end

  // equals decision
  always_comb begin
    eq_res  = '{ev: EV_ERROR, data: 8'd0, end_tag: etag_q, last: 1'b0};
    eq_err  = 1'b0;
    eq_mode = MODE_EQUALS;
    if (is_space(byte_in_i)) begin
      eq_mode = MODE_EQUALS;
    end else if (byte_in_i == ChEq) begin
      eq_mode = MODE_VALSTART;
    end else begin
      eq_err  = 1'b1;
      eq_mode = MODE_TEXT;
    end
  end

  // main lexer: next state and up to two result words for this byte
  always_comb begin
    result_t err_w;
    err_w  = '{ev: EV_ERROR, data: 8'd0, end_tag: etag_q, last: 1'b0};
    mode_d = mode_q;
    pend_d = pend_q;
    etag_d = etag_q;
    res_a  = err_w;
    res_b  = err_w;
    res_n  = 2'd0;
    case (mode_q)
      MODE_TEXT: begin
        if (byte_in_i == ChLt) begin
          res_a  = '{ev: EV_TEXT_END, data: 8'd0, end_tag: 1'b0, last: 1'b0};
          res_n  = pend_q ? 2'd1 : 2'd0;
          pend_d = 1'b0;
          etag_d = 1'b0;
          mode_d = MODE_TAGSTART;
        end else begin
          res_a  = '{ev: EV_TEXT_CHAR, data: byte_in_i, end_tag: 1'b0, last: 1'b0};
          res_n  = 2'd1;
          pend_d = 1'b1;
        end
      end
      MODE_TAGSTART: begin
        if (is_space(byte_in_i)) begin
          mode_d = MODE_TAGSTART;
        end else if (byte_in_i == ChSlash) begin
          etag_d = 1'b1;
        end else if (is_alnum(byte_in_i)) begin
          res_a  = '{ev: EV_NAME_CHAR, data: byte_in_i, end_tag: etag_q, last: 1'b0};
          res_n  = 2'd1;
          mode_d = MODE_TAGNAME;
        end else begin
          res_n  = 2'd1;
          mode_d = MODE_TEXT;
          pend_d = 1'b0;
          etag_d = 1'b0;
        end
      end
      MODE_TAGNAME: begin
        if (is_alnum(byte_in_i)) begin
          res_a = '{ev: EV_NAME_CHAR, data: byte_in_i, end_tag: etag_q, last: 1'b0};
          res_n = 2'd1;
        end else begin
          res_a  = '{ev: EV_NAME_END, data: 8'd0, end_tag: etag_q, last: 1'b0};
          res_b  = gap_res;
          res_n  = gap_has ? 2'd2 : 2'd1;
          mode_d = gap_mode;
          if (gap_err) begin
            pend_d = 1'b0;
            etag_d = 1'b0;
          end
        end
      end
      MODE_ATTRGAP: begin
        res_a  = gap_res;
        res_n  = gap_has ? 2'd1 : 2'd0;
        mode_d = gap_mode;
        if (gap_err) begin
          pend_d = 1'b0;
          etag_d = 1'b0;
        end
      end
      MODE_ATTRNAME: begin
        if (is_alnum(byte_in_i)) begin
          res_a = '{ev: EV_ATTR_CHAR, data: byte_in_i, end_tag: etag_q, last: 1'b0};
          res_n = 2'd1;
        end else begin
          res_a  = '{ev: EV_ATTR_END, data: 8'd0, end_tag: etag_q, last: 1'b0};
          res_b  = eq_res;
          res_n  = eq_err ? 2'd2 : 2'd1;
          mode_d = eq_mode;
          if (eq_err) begin
            pend_d = 1'b0;
            etag_d = 1'b0;
          end
        end
      end
      MODE_EQUALS: begin
        res_a  = eq_res;
        res_n  = eq_err ? 2'd1 : 2'd0;
        mode_d = eq_mode;
        if (eq_err) begin
          pend_d = 1'b0;
          etag_d = 1'b0;
        end
      end
      MODE_VALSTART: begin
        if (is_space(byte_in_i)) begin
          mode_d = MODE_VALSTART;
        end else if (byte_in_i == ChQuote) begin
          mode_d = MODE_VALUE;
        end else begin
          res_n  = 2'd1;
          mode_d = MODE_TEXT;
          pend_d = 1'b0;
          etag_d = 1'b0;
        end
      end
      MODE_VALUE: begin
        if (byte_in_i == ChQuote) begin
          res_a  = '{ev: EV_VALUE_END, data: 8'd0, end_tag: etag_q, last: 1'b0};
          mode_d = MODE_ATTRGAP;
        end else begin
          res_a = '{ev: EV_VALUE_CHAR, data: byte_in_i, end_tag: etag_q, last: 1'b0};
        end
        res_n = 2'd1;
      end
      default: begin
        mode_d = MODE_TEXT;
      end
    endcase
    // mark the final word of this byte
    res_a.last = (res_n == 2'd1);
    res_b.last = 1'b1;
  end

  // queue: shift out at slot 0, append new words behind what stays
  always_comb begin
    logic [QIdxW-1:0] base;
    base  = cnt_q - QIdxW'(pop);
    cnt_d = base;
    for (int i = 0; i < QDepth; i++) begin
      if (pop && i < QDepth - 1) begin
        slot_d[i] = slot_q[i + 1];
      end else begin
        slot_d[i] = slot_q[i];
      end
      if (accept && res_n != 2'd0 && QIdxW'(i) == base) begin
        slot_d[i] = res_a;
      end
      if (accept && res_n == 2'd2 && QIdxW'(i) == base + QIdxW'(1)) begin
        slot_d[i] = res_b;
      end
    end
    if (accept) begin
      cnt_d = base + QIdxW'(res_n);
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_TEXT;
      pend_q <= 1'b0;
      etag_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (accept) begin
        mode_q <= mode_d;
        pend_q <= pend_d;
        etag_q <= etag_d;
      end
    end
  end

  // queue payload
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < QDepth; i++) begin
      slot_q[i] <= slot_d[i];
    end
  end

  assign out_valid_o  = (cnt_q != '0);
  assign event_res_o  = slot_q[0].ev;
  assign data_byte_o  = slot_q[0].data;
  assign is_end_tag_o = slot_q[0].end_tag;
  assign last_o       = slot_q[0].last;

`include "assert_macros.svh"

  `ASSERT_NEXT(a_text_char_out,
               accept && mode_q == MODE_TEXT && byte_in_i != ChLt,
               out_valid_o, "text byte gave no word")
  `ASSERT_NEXT(a_lt_to_tag,
               accept && mode_q == MODE_TEXT && byte_in_i == ChLt,
               mode_q == MODE_TAGSTART && !etag_q, "'<' did not open a tag")
  `ASSERT_IMPL(a_err_last,
               out_valid_o && event_res_o == EV_ERROR,
               last_o, "error word not last of its byte")
  `ASSERT_IMPL(a_text_no_etag,
               out_valid_o && (event_res_o == EV_TEXT_CHAR || event_res_o == EV_TEXT_END),
               !is_end_tag_o, "text word carries end-tag flag")
  `ASSERT_IMPL(a_queue_room,
               accept,
               cnt_q <= QIdxW'(1), "byte taken without room for two words")

endmodule

`default_nettype wire
